// ===== hw/rtl/mphp_pkg.sv =====
`default_nettype none

package mphp_pkg;

  // Parse phase of the byte stream
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_LENGTH = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  // Role of one byte within its packet
  typedef enum logic [2:0] {
    ROLE_TYPE      = 3'd0,
    ROLE_LENGTH    = 3'd1,
    ROLE_TOPIC_LEN = 3'd2,
    ROLE_TOPIC     = 3'd3,
    ROLE_PACKET_ID = 3'd4,
    ROLE_ACK       = 3'd5,
    ROLE_OTHER     = 3'd6
  } role_t;

  // Control packet types that the parser looks into
  localparam logic [3:0] T_CONNACK  = 4'd2;
  localparam logic [3:0] T_PUBLISH  = 4'd3;
  localparam logic [3:0] T_PUBACK   = 4'd4;
  localparam logic [3:0] T_PUBREC   = 4'd5;
  localparam logic [3:0] T_PUBCOMP  = 4'd7;
  localparam logic [3:0] T_SUBACK   = 4'd9;
  localparam logic [3:0] T_UNSUBACK = 4'd11;

  // Fixed header size before any continuation length byte
  localparam logic [2:0] HDR_MIN = 3'd2;

  // One input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_packet;
  } item_t;

  // One result word
  typedef struct packed {
    role_t       byte_role;
    logic [3:0]  packet_type;
    logic        dup_flag;
    logic [1:0]  qos_level;
    logic        retain_flag;
    logic [27:0] remaining_length;
    logic [28:0] total_size;
    logic [15:0] topic_length;
    logic [15:0] packet_id;
    logic        session_flag;
    logic [7:0]  ret_code;
    logic [27:0] payload_bytes;
  } result_t;

  // Types that carry a packet identifier right after the fixed header
  function automatic logic has_ident(input logic [3:0] t);
    return (t == T_PUBACK) || (t == T_PUBREC) || (t == T_PUBCOMP) ||
           (t == T_SUBACK) || (t == T_UNSUBACK);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mphp_in_stage.sv =====
`default_nettype none

module mphp_in_stage (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire mphp_pkg::item_t in_item,
  output logic                item_valid,
  input  wire logic           item_take,
  output mphp_pkg::item_t     item
);
  import mphp_pkg::*;

  // Register is free when empty or drained this cycle
  assign in_ready = !item_valid || item_take;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mphp_parser.sv =====
`default_nettype none

module mphp_parser #(
  parameter int unsigned MAX_LENGTH_BYTES = 4
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  output logic                 item_take,
  input  wire mphp_pkg::item_t item,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output mphp_pkg::result_t    res
);
  import mphp_pkg::*;

  // Parser state
  phase_t      phase, phase_step, phase_next;
  logic [28:0] pos, pos_next;
  logic [2:0]  hdr, hdr_next;
  logic [27:0] accum, accum_next;
  logic [7:0]  tf, tf_next;
  logic [15:0] topic, topic_next;
  logic [15:0] ident, ident_next;
  logic [8:0]  ack, ack_next;

  // Step intermediates
  role_t       role;
  logic [7:0]  b;
  logic [1:0]  len_k;
  logic [27:0] len_add;
  logic        len_more;
  logic [28:0] offset;
  logic [28:0] topic_end;
  logic [28:0] ident_end;
  logic [3:0]  ptype_cur;
  logic [28:0] total;
  logic [17:0] sub;
  logic [27:0] payload;
  logic        step;

  // One byte is parsed whenever the result register can take its word
  assign step      = item_valid && (!out_valid || out_ready);
  assign item_take = step;

  assign b         = item.data_byte;
  assign ptype_cur = tf[7:4];
  assign len_k     = pos[1:0] - 2'd1;
  assign len_more  = b[7] && (({1'b0, len_k} + 3'd1) < 3'(MAX_LENGTH_BYTES));
  assign offset    = pos - {26'd0, hdr};
  assign topic_end = {13'd0, topic} + 29'd2;
  assign ident_end = {13'd0, topic} + 29'd4;

  // Place the 7-bit length group
  always_comb begin
    unique case (len_k)
      2'd0: len_add = {21'd0, b[6:0]};
      2'd1: len_add = {14'd0, b[6:0], 7'd0};
      2'd2: len_add = {7'd0, b[6:0], 14'd0};
      2'd3: len_add = {b[6:0], 21'd0};
      default: len_add = '0;
    endcase
  end

  // Byte step: field updates and byte role
  always_comb begin
    phase_step = phase;
    pos_next   = pos;
    hdr_next   = hdr;
    accum_next = accum;
    tf_next    = tf;
    topic_next = topic;
    ident_next = ident;
    ack_next   = ack;
    role       = ROLE_OTHER;
    priority if (item.start_packet || (phase != PH_LENGTH && phase != PH_BODY)) begin
      // first header byte, clears the packet in progress
      tf_next    = b;
      hdr_next   = HDR_MIN;
      accum_next = '0;
      topic_next = '0;
      ident_next = '0;
      ack_next   = '0;
      pos_next   = 29'd1;
      phase_step = PH_LENGTH;
      role       = ROLE_TYPE;
    end else if (phase == PH_LENGTH) begin
      accum_next = accum + len_add;
      if (len_more) begin
        hdr_next = hdr + 3'd1;
      end else begin
        phase_step = PH_BODY;
      end
      pos_next = pos + 29'd1;
      role     = ROLE_LENGTH;
    end else begin
      pos_next = pos + 29'd1;
      if (ptype_cur == T_PUBLISH) begin
        priority if (offset < 29'd2) begin
          topic_next = {topic[7:0], b};
          role       = ROLE_TOPIC_LEN;
        end else if (offset < topic_end) begin
          role = ROLE_TOPIC;
        end else if (tf[2:1] != 2'd0 && offset < ident_end) begin
          ident_next = {ident[7:0], b};
          role       = ROLE_PACKET_ID;
        end else begin
          role = ROLE_OTHER;
        end
      end else if (has_ident(ptype_cur)) begin
        priority if (offset < 29'd2) begin
          ident_next = {ident[7:0], b};
          role       = ROLE_PACKET_ID;
        end else if (ptype_cur == T_SUBACK && offset == 29'd2) begin
          ack_next = {ack[8], b};
          role     = ROLE_ACK;
        end else begin
          role = ROLE_OTHER;
        end
      end else if (ptype_cur == T_CONNACK) begin
        priority if (offset == 29'd0) begin
          ack_next = {b[0], ack[7:0]};
          role     = ROLE_ACK;
        end else if (offset == 29'd1) begin
          ack_next = {ack[8], b};
          role     = ROLE_ACK;
        end else begin
          role = ROLE_OTHER;
        end
      end
    end
  end

  // Packet end: total size reached in the body
  assign total = {26'd0, hdr_next} + {1'b0, accum_next};

  always_comb begin
    if (phase_step == PH_BODY && pos_next >= total) begin
      phase_next = PH_FIRST;
    end else begin
      phase_next = phase_step;
    end
  end

  // Publish payload size, saturated at zero
  always_comb begin
    sub     = 18'd2 + {2'd0, topic_next} + ((tf_next[2:1] != 2'd0) ? 18'd2 : 18'd0);
    payload = '0;
    if (tf_next[7:4] == T_PUBLISH && accum_next > {10'd0, sub}) begin
      payload = accum_next - {10'd0, sub};
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FIRST;
      pos   <= '0;
      hdr   <= HDR_MIN;
      accum <= '0;
      tf    <= '0;
      topic <= '0;
      ident <= '0;
      ack   <= '0;
    end else if (step) begin
      phase <= phase_next;
      pos   <= pos_next;
      hdr   <= hdr_next;
      accum <= accum_next;
      tf    <= tf_next;
      topic <= topic_next;
      ident <= ident_next;
      ack   <= ack_next;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (step) begin
      res.byte_role        <= role;
      res.packet_type      <= tf_next[7:4];
      res.dup_flag         <= tf_next[3];
      res.qos_level        <= tf_next[2:1];
      res.retain_flag      <= tf_next[0];
      res.remaining_length <= accum_next;
      res.total_size       <= total;
      res.topic_length     <= topic_next;
      res.packet_id        <= ident_next;
      res.session_flag     <= ack_next[8];
      res.ret_code         <= ack_next[7:0];
      res.payload_bytes    <= payload;
    end
  end

  // A start byte always leaves the parser at the first length byte
  a_start_resync: assert property (@(posedge clk) disable iff (rst)
    step && item.start_packet |=> phase == PH_LENGTH && pos == 29'd1)
    else $error("start byte did not resync parser");

  // Header size stays within the fixed header plus allowed length bytes
  a_hdr_range: assert property (@(posedge clk) disable iff (rst)
    hdr >= HDR_MIN && {1'b0, hdr} <= 4'(MAX_LENGTH_BYTES) + 4'd1)
    else $error("header size out of range");

  // Length bytes only at positions 1 to MAX_LENGTH_BYTES
  a_len_pos: assert property (@(posedge clk) disable iff (rst)
    phase == PH_LENGTH |-> pos != 29'd0 && pos <= 29'(MAX_LENGTH_BYTES))
    else $error("length phase at bad byte position");

  // A type byte word carries cleared packet fields
  a_type_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.byte_role == ROLE_TYPE |->
      res.topic_length == 16'd0 && res.packet_id == 16'd0 &&
      res.ret_code == 8'd0 && res.remaining_length == 28'd0)
    else $error("type byte word with stale fields");

endmodule

`default_nettype wire

// ===== hw/rtl/mqtt_packet_header_parser_unit.sv =====
// MQTT packet header parser.
// Input channel: one stream byte per word (data_byte) with start_packet,
// which forces the byte to be taken as the first byte of a new packet.
// Output channel: exactly one result word per input byte, giving the byte's
// role and the running header fields after that byte (type and flags,
// remaining length, total size, topic length, packet id, ack fields and
// publish payload size).
// Both channels use valid/ready; a word moves when both are high.
// Path: the input register takes the byte, then the parse logic writes the
// result register and raises out_valid.
// Throughput: one byte per cycle while out_ready stays high; the parse
// state and the result register update together once per byte.
// Reset: the parser expects a first header byte, all fields clear, both
// registers empty.
// Receiver stall: the result register holds its word, the input register
// fills only if empty, then in_ready stays low until out_ready returns.
`default_nettype none

module mqtt_packet_header_parser_unit #(
  parameter int unsigned MAX_LENGTH_BYTES = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        start_packet,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       byte_role,
  output logic [3:0]       packet_type,
  output logic             dup_flag,
  output logic [1:0]       qos_level,
  output logic             retain_flag,
  output logic [27:0]      remaining_length,
  output logic [28:0]      total_size,
  output logic [15:0]      topic_length,
  output logic [15:0]      packet_id,
  output logic             session_flag,
  output logic [7:0]       ret_code,
  output logic [27:0]      payload_bytes
);
  import mphp_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    item_take;
  result_t res;

  assign in_item.data_byte    = data_byte;
  assign in_item.start_packet = start_packet;

  // Input register
  mphp_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item_take  (item_take),
    .item       (item)
  );

  // Parse logic, state and result register
  mphp_parser #(
    .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_take  (item_take),
    .item       (item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .res        (res)
  );

  // Result word to ports
  assign byte_role        = res.byte_role;
  assign packet_type      = res.packet_type;
  assign dup_flag         = res.dup_flag;
  assign qos_level        = res.qos_level;
  assign retain_flag      = res.retain_flag;
  assign remaining_length = res.remaining_length;
  assign total_size       = res.total_size;
  assign topic_length     = res.topic_length;
  assign packet_id        = res.packet_id;
  assign session_flag     = res.session_flag;
  assign ret_code         = res.ret_code;
  assign payload_bytes    = res.payload_bytes;

endmodule

`default_nettype wire

// ===== dv/mqtt_packet_header_parser_unit_tb.sv =====
`default_nettype none

module mqtt_packet_header_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mphp_pkg::*;

  localparam int MAX_LEN_BYTES  = 4;
  localparam int NUM_WORDS      = 1350;
  localparam int SEG_WORDS      = 150;
  localparam int HOLD_CYCLES    = 80;
  localparam int DRAIN_CYCLES   = 20;
  localparam int TIMEOUT_CYCLES = 600000;
  localparam int MAX_REPORTS    = 200;

  // Fields typed in by hand for rows whose result is obvious
  typedef struct packed {
    logic        on;
    role_t       role;
    logic [3:0]  ptype;
    logic [27:0] rem_len;
    logic [28:0] total;
  } pin_t;

  typedef struct packed {
    logic [7:0] b;
    logic       s;
    pin_t       pin;
  } dir_row_t;

  localparam pin_t PIN_NONE = '0;
  localparam logic [3:0] IDENT_TYPES [4] = '{T_PUBACK, T_PUBREC, T_PUBCOMP, T_UNSUBACK};

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        start_packet = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  byte_role;
  logic [3:0]  packet_type;
  logic        dup_flag;
  logic [1:0]  qos_level;
  logic        retain_flag;
  logic [27:0] remaining_length;
  logic [28:0] total_size;
  logic [15:0] topic_length;
  logic [15:0] packet_id;
  logic        session_flag;
  logic [7:0]  ret_code;
  logic [27:0] payload_bytes;

  pin_t word_pin = '0;

  // Parser state as the scoreboard sees it
  phase_t      p_phase;
  logic [28:0] p_pos;
  logic [2:0]  p_hdr;
  logic [27:0] p_len;
  logic [7:0]  p_tf;
  logic [15:0] p_topic;
  logic [15:0] p_ident;
  logic [8:0]  p_ack;

  result_t     expected_q[$];
  logic [8:0]  pkt_words[$];   // {start, byte}
  int unsigned words_sent = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  bit          tx_idle_en = 1'b0;
  bit          rx_stall_en = 1'b0;
  bit          hold_request = 1'b0;
  bit          resync_next = 1'b0;

  // Directed words: reset, zero length, publish, longest length, restart
  // mid-packet, CONNACK, SUBACK, publish with qos 3 and payload underflow
  dir_row_t directed_rows [26] = '{
    '{8'hFF, 1'b0, '{1'b1, ROLE_TYPE,   4'hF, 28'd0,         29'd2}},
    '{8'h00, 1'b0, '{1'b1, ROLE_LENGTH, 4'hF, 28'd0,         29'd2}},
    '{8'h3B, 1'b0, '{1'b1, ROLE_TYPE,   4'h3, 28'd0,         29'd2}},
    '{8'h05, 1'b0, PIN_NONE},
    '{8'h00, 1'b0, PIN_NONE},
    '{8'h00, 1'b0, PIN_NONE},
    '{8'h12, 1'b0, PIN_NONE},
    '{8'h34, 1'b0, PIN_NONE},
    '{8'hFF, 1'b0, PIN_NONE},
    '{8'h10, 1'b1, '{1'b1, ROLE_TYPE,   4'h1, 28'd0,         29'd2}},
    '{8'hFF, 1'b0, '{1'b1, ROLE_LENGTH, 4'h1, 28'd127,       29'd130}},
    '{8'hFF, 1'b0, '{1'b1, ROLE_LENGTH, 4'h1, 28'd16383,     29'd16387}},
    '{8'hFF, 1'b0, '{1'b1, ROLE_LENGTH, 4'h1, 28'd2097151,   29'd2097156}},
    '{8'hFF, 1'b0, '{1'b1, ROLE_LENGTH, 4'h1, 28'd268435455, 29'd268435460}},
    '{8'h20, 1'b1, '{1'b1, ROLE_TYPE,   4'h2, 28'd0,         29'd2}},
    '{8'h02, 1'b0, PIN_NONE},
    '{8'h01, 1'b0, PIN_NONE},
    '{8'h05, 1'b0, PIN_NONE},
    '{8'h90, 1'b0, PIN_NONE},
    '{8'h03, 1'b0, PIN_NONE},
    '{8'hAB, 1'b0, PIN_NONE},
    '{8'hCD, 1'b0, PIN_NONE},
    '{8'h80, 1'b0, PIN_NONE},
    '{8'h36, 1'b0, '{1'b1, ROLE_TYPE,   4'h3, 28'd0,         29'd2}},
    '{8'h01, 1'b0, PIN_NONE},
    '{8'h00, 1'b0, PIN_NONE}
  };

  mqtt_packet_header_parser_unit #(
    .MAX_LENGTH_BYTES(MAX_LEN_BYTES)
  ) dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .data_byte        (data_byte),
    .start_packet     (start_packet),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .byte_role        (byte_role),
    .packet_type      (packet_type),
    .dup_flag         (dup_flag),
    .qos_level        (qos_level),
    .retain_flag      (retain_flag),
    .remaining_length (remaining_length),
    .total_size       (total_size),
    .topic_length     (topic_length),
    .packet_id        (packet_id),
    .session_flag     (session_flag),
    .ret_code         (ret_code),
    .payload_bytes    (payload_bytes)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void clear_parser();
    p_phase = PH_FIRST;
    p_pos   = '0;
    p_hdr   = HDR_MIN;
    p_len   = '0;
    p_tf    = '0;
    p_topic = '0;
    p_ident = '0;
    p_ack   = '0;
  endfunction

  // Advance the parser by one stream byte and return the header view after it
  function automatic result_t parse_stream_byte(input logic [7:0] b, input logic s);
    result_t     r;
    role_t       role;
    logic [1:0]  grp;
    logic [28:0] off;
    logic [28:0] total;
    logic [3:0]  t;
    logic [17:0] sub;
    logic [27:0] payload;
    t = p_tf[7:4];
    if (s || p_phase == PH_FIRST) begin
      // first header byte, everything of the old packet is dropped
      p_tf    = b;
      p_hdr   = HDR_MIN;
      p_len   = '0;
      p_topic = '0;
      p_ident = '0;
      p_ack   = '0;
      p_pos   = 29'd1;
      p_phase = PH_LENGTH;
      role    = ROLE_TYPE;
    end else if (p_phase == PH_LENGTH) begin
      // 7-bit groups, little end first; last allowed byte ends the field
      grp   = 2'(p_pos - 29'd1);
      p_len = p_len + (28'(b[6:0]) << (7 * grp));
      if (b[7] && (int'(grp) + 1 < MAX_LEN_BYTES)) begin
        p_hdr = p_hdr + 3'd1;
      end else begin
        p_phase = PH_BODY;
      end
      p_pos = p_pos + 29'd1;
      role  = ROLE_LENGTH;
    end else begin
      role = ROLE_OTHER;
      off  = p_pos - 29'(p_hdr);
      if (t == T_PUBLISH) begin
        if (off < 29'd2) begin
          p_topic = {p_topic[7:0], b};
          role    = ROLE_TOPIC_LEN;
        end else if ({3'b0, off} < 32'd2 + p_topic) begin
          role = ROLE_TOPIC;
        end else if (p_tf[2:1] != 2'b00 && {3'b0, off} < 32'd4 + p_topic) begin
          p_ident = {p_ident[7:0], b};
          role    = ROLE_PACKET_ID;
        end
      end else if (t inside {T_PUBACK, T_PUBREC, T_PUBCOMP, T_SUBACK, T_UNSUBACK}) begin
        if (off < 29'd2) begin
          p_ident = {p_ident[7:0], b};
          role    = ROLE_PACKET_ID;
        end else if (t == T_SUBACK && off == 29'd2) begin
          p_ack[7:0] = b;
          role       = ROLE_ACK;
        end
      end else if (t == T_CONNACK) begin
        if (off == 29'd0) begin
          p_ack[8] = b[0];
          role     = ROLE_ACK;
        end else if (off == 29'd1) begin
          p_ack[7:0] = b;
          role       = ROLE_ACK;
        end
      end
      p_pos = p_pos + 29'd1;
    end

    // packet end once header plus remaining length is consumed
    total = 29'(p_hdr) + 29'(p_len);
    if (p_phase == PH_BODY && p_pos >= total) p_phase = PH_FIRST;

    // payload left after topic and optional id, floored at zero
    t       = p_tf[7:4];
    payload = '0;
    if (t == T_PUBLISH) begin
      sub = 18'd2 + 18'(p_topic) + ((p_tf[2:1] != 2'b00) ? 18'd2 : 18'd0);
      if (p_len > 28'(sub)) payload = p_len - 28'(sub);
    end

    r.byte_role        = role;
    r.packet_type      = t;
    r.dup_flag         = p_tf[3];
    r.qos_level        = p_tf[2:1];
    r.retain_flag      = p_tf[0];
    r.remaining_length = p_len;
    r.total_size       = total;
    r.topic_length     = p_topic;
    r.packet_id        = p_ident;
    r.session_flag     = p_ack[8];
    r.ret_code         = p_ack[7:0];
    r.payload_bytes    = payload;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      if (fail_count < MAX_REPORTS)
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Scoreboard: predict on input accept, compare on output accept
  always @(posedge clk) begin : scoreboard
    result_t r;
    if (!rst) begin
      if (in_valid && in_ready) begin
        r = parse_stream_byte(data_byte, start_packet);
        if (word_pin.on) begin
          r.byte_role        = word_pin.role;
          r.packet_type      = word_pin.ptype;
          r.remaining_length = word_pin.rem_len;
          r.total_size       = word_pin.total;
        end
        expected_q.push_back(r);
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          if (fail_count < MAX_REPORTS) $error("result word with none expected");
          fail_count++;
        end else begin
          r = expected_q.pop_front();
          check_field("byte_role",        32'(r.byte_role),        32'(byte_role));
          check_field("packet_type",      32'(r.packet_type),      32'(packet_type));
          check_field("dup_flag",         32'(r.dup_flag),         32'(dup_flag));
          check_field("qos_level",        32'(r.qos_level),        32'(qos_level));
          check_field("retain_flag",      32'(r.retain_flag),      32'(retain_flag));
          check_field("remaining_length", 32'(r.remaining_length), 32'(remaining_length));
          check_field("total_size",       32'(r.total_size),       32'(total_size));
          check_field("topic_length",     32'(r.topic_length),     32'(topic_length));
          check_field("packet_id",        32'(r.packet_id),        32'(packet_id));
          check_field("session_flag",     32'(r.session_flag),     32'(session_flag));
          check_field("ret_code",         32'(r.ret_code),         32'(ret_code));
          check_field("payload_bytes",    32'(r.payload_bytes),    32'(payload_bytes));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(15, 40);
    return $urandom_range(1, 3);
  endfunction

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rx_stall_en && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_word(input logic [7:0] b, input logic s, input pin_t pin);
    data_byte    <= b;
    start_packet <= s;
    word_pin     <= pin;
    in_valid     <= 1'b1;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat (idle_len()) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
  endtask

  // One packet of words: mostly well formed with random content, some
  // with broken lengths, some plain noise
  function automatic void make_packet();
    logic [7:0]  body[$];
    logic [3:0]  ptype;
    logic [3:0]  flags;
    logic [7:0]  lb;
    int unsigned tlen;
    int unsigned n;
    int unsigned len_mode;
    int unsigned declared;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4))
        pkt_words.push_back({1'($urandom_range(0, 1)), 8'($urandom)});
      return;
    end
    case ($urandom_range(0, 9))
      0, 1, 2: ptype = T_PUBLISH;
      3:       ptype = T_CONNACK;
      4:       ptype = T_SUBACK;
      5:       ptype = IDENT_TYPES[$urandom_range(0, 3)];
      default: ptype = 4'($urandom);
    endcase
    flags = 4'($urandom);
    if (ptype == T_PUBLISH) begin
      // topic length sometimes runs past the packet end
      tlen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 4);
      body.push_back(tlen[15:8]);
      body.push_back(tlen[7:0]);
      repeat ((tlen < 6) ? tlen : 3) body.push_back(8'($urandom));
      if (flags[2:1] != 2'b00) repeat (2) body.push_back(8'($urandom));
      n = ($urandom_range(0, 39) == 0) ? $urandom_range(120, 200) : $urandom_range(0, 5);
      repeat (n) body.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(0, 4)) body.push_back(8'($urandom));
    end

    pkt_words.push_back({resync_next | ($urandom_range(0, 3) == 0), ptype, flags});
    resync_next = 1'b0;
    declared = body.size();
    len_mode = $urandom_range(0, 9);
    if (len_mode == 8) begin
      // garbage length field, often with continuation on its last byte
      repeat (3) pkt_words.push_back({1'b0, 1'b1, 7'($urandom)});
      pkt_words.push_back({1'b0, 8'($urandom)});
      resync_next = 1'b1;
    end else if (len_mode == 7 && declared < 128) begin
      // padded encoding with zero groups
      pkt_words.push_back({1'b0, 1'b1, 7'(declared)});
      repeat ($urandom_range(0, 1)) pkt_words.push_back({1'b0, 8'h80});
      pkt_words.push_back({1'b0, 8'h00});
    end else begin
      if (len_mode == 9) begin
        declared += $urandom_range(1, 3);
        resync_next = 1'b1;
      end
      n = declared;
      do begin
        lb    = {1'b0, 7'(n)};
        n     = n >> 7;
        lb[7] = (n != 0);
        pkt_words.push_back({1'b0, lb});
      end while (n != 0);
    end
    foreach (body[i]) pkt_words.push_back({1'b0, body[i]});
  endfunction

  // Main sequence
  initial begin
    int unsigned seg;
    int unsigned seg_goal;
    logic [8:0]  w;
    clear_parser();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed part
    tx_idle_en  = 1'b1;
    rx_stall_en = 1'b1;
    foreach (directed_rows[i])
      send_word(directed_rows[i].b, directed_rows[i].s, directed_rows[i].pin);
    drain_results();

    // random part in segments of differing pressure
    seg = 0;
    while (words_sent < NUM_WORDS) begin
      case (seg)
        0: begin
          tx_idle_en  = 1'b0;
          rx_stall_en = 1'b0;
        end
        1: begin
          tx_idle_en   = 1'b0;
          rx_stall_en  = 1'b0;
          hold_request = 1'b1;
        end
        default: begin
          tx_idle_en  = ($urandom_range(0, 3) != 0);
          rx_stall_en = ($urandom_range(0, 3) != 0);
        end
      endcase
      seg_goal = words_sent + SEG_WORDS;
      while (words_sent < seg_goal && words_sent < NUM_WORDS) begin
        make_packet();
        while (pkt_words.size() != 0) begin
          w = pkt_words.pop_front();
          send_word(w[7:0], w[8], PIN_NONE);
        end
      end
      // sender pause until the pipe is empty
      if (seg == 3) drain_results();
      seg++;
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== mqtt_packet_header_parser_unit.f =====
hw/rtl/mphp_pkg.sv
hw/rtl/mphp_in_stage.sv
hw/rtl/mphp_parser.sv
hw/rtl/mqtt_packet_header_parser_unit.sv
dv/mqtt_packet_header_parser_unit_tb.sv
